[rtl/stwe_pkg.sv]
package stwe_pkg;

    localparam int TIME_W = 32;
    localparam int ROLE_W = 2;
    localparam int SLOT_W = 2;
    localparam int KEY_W  = 64;
    localparam int OP_W   = 3;

    typedef enum logic [OP_W-1:0] {
        OP_CREATE    = 3'd0,
        OP_LOOKUP    = 3'd1,
        OP_EXTEND    = 3'd2,
        OP_CSRF      = 3'd3,
        OP_DESTROY   = 3'd4,
        OP_REMAINING = 3'd5
    } t_op;

    // one stored session
    typedef struct packed {
        logic [TIME_W-1:0] expiry;
        logic [ROLE_W-1:0] role;
        logic [KEY_W-1:0]  token_high;
        logic [KEY_W-1:0]  token_low;
        logic [KEY_W-1:0]  csrf_high;
        logic [KEY_W-1:0]  csrf_low;
    } t_entry;

    // flags and time from the shared compare unit
    typedef struct packed {
        logic              expired;
        logic              earlier;
        logic              tok_match;
        logic              csrf_match;
        logic [TIME_W-1:0] remaining;
    } t_cmp;

endpackage

[rtl/stwe_ram.sv]
module stwe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/stwe_cmp.sv]
module stwe_cmp (
    input  logic [stwe_pkg::TIME_W-1:0] i_now,
    input  logic [stwe_pkg::TIME_W-1:0] i_exp,
    input  logic [stwe_pkg::TIME_W-1:0] i_best,
    input  stwe_pkg::t_entry            i_entry,
    input  logic [stwe_pkg::KEY_W-1:0]  i_token_high,
    input  logic [stwe_pkg::KEY_W-1:0]  i_token_low,
    input  logic [stwe_pkg::KEY_W-1:0]  i_csrf_high,
    input  logic [stwe_pkg::KEY_W-1:0]  i_csrf_low,
    output stwe_pkg::t_cmp              o_cmp
);
    import stwe_pkg::*;

    logic [TIME_W-1:0] w_now_minus_exp;
    logic [TIME_W-1:0] w_exp_minus_best;

    // wrap-aware: a is before b when a - b is negative
    assign w_now_minus_exp  = i_now - i_exp;
    assign w_exp_minus_best = i_exp - i_best;

    assign o_cmp.expired    = ~w_now_minus_exp[TIME_W-1];
    assign o_cmp.earlier    = w_exp_minus_best[TIME_W-1];
    assign o_cmp.remaining  = i_exp - i_now;
    assign o_cmp.tok_match  = (i_entry.token_high == i_token_high) &&
                              (i_entry.token_low == i_token_low);
    assign o_cmp.csrf_match = (i_entry.csrf_high == i_csrf_high) &&
                              (i_entry.csrf_low == i_csrf_low);

endmodule

[rtl/session_table_with_expiry.sv]
// session table with expiry
// input channel: i_in_valid / o_in_stall, one item per operation (create, lookup,
// extend, csrf check, destroy, remaining); an item is taken at a clock edge with
// valid high and stall low. stall is high whenever the sequencer is busy.
// output channel: o_out_valid / i_out_stall, exactly one result item per input item,
// held in an output register that stays stable while the receiver stalls.
// the sequencer walks the slot memory one slot at a time: each slot goes through a
// read state and an evaluate state with the one shared time/key compare unit.
// create and destroy walk every slot, and create writes its pick in a final step;
// lookup stops at its first live match; extend, csrf check and remaining read only
// the addressed slot (extend adds a final step); unused codes go straight to done.
// the next item can be accepted in the cycle after the result is loaded. a new
// item is accepted as soon as the result sits in the output register, even if it
// is still stalled; a finished result waits only while the one before it is still
// stalled.
// i_cfg_we / i_cfg_data write the session lifetime; write only while idle.
// reset (i_rst_n low, synchronous) clears all slot valid bits, the output
// valid bit and sets the lifetime to 1800000 ms. slot contents are not cleared.
module session_table_with_expiry #(
    parameter int SESSION_SLOTS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_data,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_operation,
    input  logic [31:0] i_now_ms,
    input  logic [1:0]  i_role,
    input  logic [63:0] i_token_high,
    input  logic [63:0] i_token_low,
    input  logic [63:0] i_csrf_high,
    input  logic [63:0] i_csrf_low,
    input  logic [1:0]  i_slot,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_hit,
    output logic [1:0]  o_slot_out,
    output logic [1:0]  o_role_out,
    output logic [31:0] o_remaining_ms
);
    import stwe_pkg::*;

    localparam int AW = $clog2(SESSION_SLOTS);
    localparam logic [TIME_W-1:0] TTL_RESET = 32'd1800000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_FIN,
        ST_DONE
    } t_state;

    t_state r_state, n_state;

    // item fields held for the whole operation
    logic [OP_W-1:0]   r_op, n_op;
    logic [TIME_W-1:0] r_now, n_now;
    logic [TIME_W-1:0] r_new_exp, n_new_exp;
    logic [ROLE_W-1:0] r_role, n_role;
    logic [KEY_W-1:0]  r_th, n_th, r_tl, n_tl, r_ch, n_ch, r_cl, n_cl;
    logic [SLOT_W-1:0] r_sel, n_sel;

    // scan state
    logic [AW-1:0]     r_idx, n_idx;
    logic              r_found, n_found;
    logic [AW-1:0]     r_pick, n_pick;
    logic [TIME_W-1:0] r_best_exp, n_best_exp;
    logic [AW-1:0]     r_best_idx, n_best_idx;
    logic [SESSION_SLOTS-1:0] r_valid, n_valid;
    logic [TIME_W-1:0] r_ttl, n_ttl;

    // result being built
    logic              r_res_hit, n_res_hit;
    logic [SLOT_W-1:0] r_res_slot, n_res_slot;
    logic [ROLE_W-1:0] r_res_role, n_res_role;
    logic [TIME_W-1:0] r_res_rem, n_res_rem;

    // output register
    logic              r_o_valid, n_o_valid;
    logic              r_o_hit, n_o_hit;
    logic [SLOT_W-1:0] r_o_slot, n_o_slot;
    logic [ROLE_W-1:0] r_o_role, n_o_role;
    logic [TIME_W-1:0] r_o_rem, n_o_rem;

    // memory and compare unit hookup
    logic              w_ram_we;
    logic [AW-1:0]     w_ram_waddr;
    t_entry            w_ram_wdata;
    logic [$bits(t_entry)-1:0] w_ram_rdata;
    t_entry            w_rd;
    t_cmp              w_cmp;
    logic [TIME_W-1:0] w_cmp_exp;

    // index width conversions
    logic [AW+1:0]     w_in_sel_ext;
    logic [AW+1:0]     w_sel_ext;
    logic [AW+1:0]     w_idx_ext;
    logic [AW+1:0]     w_tgt_ext;
    logic [AW-1:0]     w_tgt;
    logic              w_sel_ok;
    logic              w_sel_live;
    logic              w_cur_valid;
    logic              w_last;
    logic              w_accept;
    logic              w_addr_op;

    assign w_in_sel_ext = {{AW{1'b0}}, i_slot};
    assign w_sel_ext    = {{AW{1'b0}}, r_sel};
    assign w_idx_ext    = {2'b00, r_idx};
    assign w_tgt        = r_found ? r_pick : r_best_idx;
    assign w_tgt_ext    = {2'b00, w_tgt};
    assign w_sel_ok     = w_sel_ext < (AW + 2)'(SESSION_SLOTS);
    assign w_cur_valid  = r_valid[r_idx];
    assign w_sel_live   = w_sel_ok ? r_valid[r_idx] : 1'b0;
    assign w_last       = r_idx == AW'(SESSION_SLOTS - 1);
    assign w_accept     = i_in_valid && (r_state == ST_IDLE);
    assign w_addr_op    = (i_operation == OP_EXTEND) || (i_operation == OP_CSRF) ||
                          (i_operation == OP_REMAINING);

    assign w_rd      = t_entry'(w_ram_rdata);
    // the final step checks the freshly written expiry
    assign w_cmp_exp = (r_state == ST_FIN) ? r_new_exp : w_rd.expiry;

    stwe_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (SESSION_SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (r_idx),
        .o_rdata (w_ram_rdata)
    );

    stwe_cmp u_cmp (
        .i_now        (r_now),
        .i_exp        (w_cmp_exp),
        .i_best       (r_best_exp),
        .i_entry      (w_rd),
        .i_token_high (r_th),
        .i_token_low  (r_tl),
        .i_csrf_high  (r_ch),
        .i_csrf_low   (r_cl),
        .o_cmp        (w_cmp)
    );

    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_now      = r_now;
        n_new_exp  = r_new_exp;
        n_role     = r_role;
        n_th       = r_th;
        n_tl       = r_tl;
        n_ch       = r_ch;
        n_cl       = r_cl;
        n_sel      = r_sel;
        n_idx      = r_idx;
        n_found    = r_found;
        n_pick     = r_pick;
        n_best_exp = r_best_exp;
        n_best_idx = r_best_idx;
        n_valid    = r_valid;
        n_res_hit  = r_res_hit;
        n_res_slot = r_res_slot;
        n_res_role = r_res_role;
        n_res_rem  = r_res_rem;
        n_o_hit    = r_o_hit;
        n_o_slot   = r_o_slot;
        n_o_role   = r_o_role;
        n_o_rem    = r_o_rem;
        // output register drains when the receiver takes it
        n_o_valid  = r_o_valid && i_out_stall;
        n_ttl      = i_cfg_we ? i_cfg_data : r_ttl;

        w_ram_we    = 1'b0;
        w_ram_waddr = r_idx;
        w_ram_wdata = w_rd;

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_op       = i_operation;
                    n_now      = i_now_ms;
                    n_new_exp  = i_now_ms + r_ttl;
                    n_role     = i_role;
                    n_th       = i_token_high;
                    n_tl       = i_token_low;
                    n_ch       = i_csrf_high;
                    n_cl       = i_csrf_low;
                    n_sel      = i_slot;
                    n_idx      = w_addr_op ? w_in_sel_ext[AW-1:0] : '0;
                    n_found    = 1'b0;
                    n_res_hit  = 1'b0;
                    n_res_slot = '0;
                    n_res_role = '0;
                    n_res_rem  = '0;
                    // unused codes give an all-zero result
                    n_state    = (i_operation > OP_REMAINING) ? ST_DONE : ST_READ;
                end
            end

            ST_READ: begin
                // slot word arrives from memory next cycle
                n_state = ST_EVAL;
            end

            ST_EVAL: begin
                unique case (t_op'(r_op))
                    OP_CREATE: begin
                        // reap, remember first free slot and soonest expiry
                        if (w_cur_valid && w_cmp.expired) begin
                            n_valid[r_idx] = 1'b0;
                        end
                        if ((!w_cur_valid || w_cmp.expired) && !r_found) begin
                            n_found = 1'b1;
                            n_pick  = r_idx;
                        end
                        if (r_idx == '0 || w_cmp.earlier) begin
                            n_best_exp = w_rd.expiry;
                            n_best_idx = r_idx;
                        end
                        if (w_last) begin
                            n_state = ST_FIN;
                        end else begin
                            n_idx   = r_idx + 1'b1;
                            n_state = ST_READ;
                        end
                    end
                    OP_LOOKUP: begin
                        n_state = ST_READ;
                        if (w_cur_valid && w_cmp.expired) begin
                            n_valid[r_idx] = 1'b0;
                        end
                        if (w_cur_valid && !w_cmp.expired && w_cmp.tok_match) begin
                            // first live match ends the scan
                            n_res_hit  = 1'b1;
                            n_res_slot = w_idx_ext[SLOT_W-1:0];
                            n_res_role = w_rd.role;
                            n_res_rem  = w_cmp.remaining;
                            n_state    = ST_DONE;
                        end else if (w_last) begin
                            n_state = ST_DONE;
                        end else begin
                            n_idx = r_idx + 1'b1;
                        end
                    end
                    OP_DESTROY: begin
                        if (w_cur_valid && w_cmp.tok_match) begin
                            n_valid[r_idx] = 1'b0;
                            n_res_hit      = 1'b1;
                        end
                        if (w_last) begin
                            n_state = ST_DONE;
                        end else begin
                            n_idx   = r_idx + 1'b1;
                            n_state = ST_READ;
                        end
                    end
                    OP_EXTEND: begin
                        n_res_slot = r_sel;
                        if (w_sel_live) begin
                            // rewrite the slot with the new expiry
                            w_ram_we           = 1'b1;
                            w_ram_wdata.expiry = r_new_exp;
                            n_res_hit          = 1'b1;
                            n_res_role         = w_rd.role;
                            n_state            = ST_FIN;
                        end else begin
                            n_state = ST_DONE;
                        end
                    end
                    OP_CSRF: begin
                        n_res_slot = r_sel;
                        if (w_sel_live) begin
                            n_res_hit  = w_cmp.csrf_match;
                            n_res_role = w_rd.role;
                        end
                        n_state = ST_DONE;
                    end
                    OP_REMAINING: begin
                        n_res_slot = r_sel;
                        if (w_sel_live && !w_cmp.expired) begin
                            n_res_hit  = 1'b1;
                            n_res_role = w_rd.role;
                            n_res_rem  = w_cmp.remaining;
                        end
                        n_state = ST_DONE;
                    end
                    default: begin
                        n_state = ST_DONE;
                    end
                endcase
            end

            ST_FIN: begin
                // compare unit now sees the new expiry
                n_res_rem = w_cmp.expired ? '0 : w_cmp.remaining;
                if (r_op == OP_CREATE) begin
                    w_ram_we               = 1'b1;
                    w_ram_waddr            = w_tgt;
                    w_ram_wdata.expiry     = r_new_exp;
                    w_ram_wdata.role       = r_role;
                    w_ram_wdata.token_high = r_th;
                    w_ram_wdata.token_low  = r_tl;
                    w_ram_wdata.csrf_high  = r_ch;
                    w_ram_wdata.csrf_low   = r_cl;
                    n_valid[w_tgt]         = 1'b1;
                    n_res_hit              = 1'b1;
                    n_res_slot             = w_tgt_ext[SLOT_W-1:0];
                    n_res_role             = r_role;
                end
                n_state = ST_DONE;
            end

            ST_DONE: begin
                if (!r_o_valid || !i_out_stall) begin
                    n_o_valid = 1'b1;
                    n_o_hit   = r_res_hit;
                    n_o_slot  = r_res_slot;
                    n_o_role  = r_res_role;
                    n_o_rem   = r_res_rem;
                    n_state   = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_valid   <= '0;
            r_o_valid <= 1'b0;
            r_ttl     <= TTL_RESET;
        end else begin
            r_state   <= n_state;
            r_valid   <= n_valid;
            r_o_valid <= n_o_valid;
            r_ttl     <= n_ttl;
        end
        r_op       <= n_op;
        r_now      <= n_now;
        r_new_exp  <= n_new_exp;
        r_role     <= n_role;
        r_th       <= n_th;
        r_tl       <= n_tl;
        r_ch       <= n_ch;
        r_cl       <= n_cl;
        r_sel      <= n_sel;
        r_idx      <= n_idx;
        r_found    <= n_found;
        r_pick     <= n_pick;
        r_best_exp <= n_best_exp;
        r_best_idx <= n_best_idx;
        r_res_hit  <= n_res_hit;
        r_res_slot <= n_res_slot;
        r_res_role <= n_res_role;
        r_res_rem  <= n_res_rem;
        r_o_hit    <= n_o_hit;
        r_o_slot   <= n_o_slot;
        r_o_role   <= n_o_role;
        r_o_rem    <= n_o_rem;
    end

    assign o_in_stall     = (r_state != ST_IDLE);
    assign o_out_valid    = r_o_valid;
    assign o_hit          = r_o_hit;
    assign o_slot_out     = r_o_slot;
    assign o_role_out     = r_o_role;
    assign o_remaining_ms = r_o_rem;

endmodule
